// ----- hdl/lsld_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsld_pkg: shared constants for the scan segment leg detector
// Field widths, register reset values, register indexes and slope limits.
// ----------------------------------------------------------------------------
package lsld_pkg;

    localparam int COORD_WIDTH_DEF = 16;
    localparam int SLOPE_FRAC_DEF  = 8;

    localparam int DIST_W      = 15;   // distance and 15 bit registers
    localparam int SPREAD_W    = 23;   // slope spread threshold register
    localparam int SLOPE_INT_W = 15;   // integer bits of a slope word, sign included
    localparam int SLOPE_SAT   = 9999; // slope saturation, integer part

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 4;

    // register indexes, paddr[3:2]
    localparam logic [1:0] REG_CLUSTER = 2'd0;
    localparam logic [1:0] REG_RANGE   = 2'd1;
    localparam logic [1:0] REG_LEGDIA  = 2'd2;
    localparam logic [1:0] REG_SPREAD  = 2'd3;

    localparam logic [DIST_W-1:0]   CLUSTER_RST = 15'd2048;
    localparam logic [DIST_W-1:0]   RANGE_RST   = 15'd15974;
    localparam logic [DIST_W-1:0]   LEGDIA_RST  = 15'd819;
    localparam logic [SPREAD_W-1:0] SPREAD_RST  = 23'd26;

endpackage

// ----- hdl/lsld_div.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lsld_div: serial slope divider
// dy * 2^FRAC_W / dx, truncated toward zero, one quotient bit per cycle,
// saturated to +-9999 * 2^FRAC_W; dx of zero gives the positive limit.
// ----------------------------------------------------------------------------
module lsld_div
    import lsld_pkg::*;
#(
    parameter int COORD_W = COORD_WIDTH_DEF,
    parameter int FRAC_W  = SLOPE_FRAC_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_start,
    input  logic signed [COORD_W:0]           i_dx,
    input  logic signed [COORD_W:0]           i_dy,
    output logic                              o_done,
    output logic [SLOPE_INT_W+FRAC_W-1:0]     o_slope
);

    localparam int DW    = COORD_W + 1;
    localparam int NB    = DW + FRAC_W;
    localparam int SW    = SLOPE_INT_W + FRAC_W;
    localparam int CMPW  = (NB > SW) ? NB : SW;
    localparam int CNT_W = $clog2(NB);
    localparam logic [CMPW-1:0] LIMIT = CMPW'(SLOPE_SAT * (2 ** FRAC_W));

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_RUN  = 2'd1;
    localparam logic [1:0] D_FIX  = 2'd2;

    logic [1:0]       r_state;
    logic [CNT_W-1:0] r_cnt;
    logic [NB-1:0]    r_num;      // numerator out at the top, quotient in at the bottom
    logic [DW-1:0]    r_rem;
    logic [DW-1:0]    r_den;
    logic             r_neg;
    logic             r_zero;

    logic [DW+1:0]    trial;
    logic             ge;
    logic [DW-1:0]    abs_dx;
    logic [DW-1:0]    abs_dy;
    logic [CMPW-1:0]  mag;
    logic [CMPW-1:0]  sat;
    logic [CMPW-1:0]  res;

    assign abs_dx = i_dx[DW-1] ? DW'(-i_dx) : DW'(i_dx);
    assign abs_dy = i_dy[DW-1] ? DW'(-i_dy) : DW'(i_dy);

    assign trial = {1'b0, r_rem, r_num[NB-1]} - {2'b00, r_den};
    assign ge    = ~trial[DW+1];

    assign mag = CMPW'(r_num);
    assign sat = (r_zero || (mag > LIMIT)) ? LIMIT : mag;
    assign res = (r_neg && !r_zero) ? (~sat + 1'b1) : sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            o_done  <= 1'b0;
        end else begin
            o_done <= 1'b0;
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_state <= D_RUN;
                    end
                end
                D_RUN: begin
                    if (r_cnt == CNT_W'(NB - 1)) begin
                        r_state <= D_FIX;
                    end
                end
                D_FIX: begin
                    o_done  <= 1'b1;
                    r_state <= D_IDLE;
                end
                default: begin
                    r_state <= D_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == D_IDLE && i_start) begin
            r_zero <= (i_dx == '0);
            r_neg  <= i_dx[DW-1] ^ i_dy[DW-1];
            r_den  <= abs_dx;
            r_num  <= {abs_dy, {FRAC_W{1'b0}}};
            r_rem  <= '0;
            r_cnt  <= '0;
        end else if (r_state == D_RUN) begin
            // restoring step: shift the next numerator bit in, subtract if it fits
            r_rem <= ge ? trial[DW-1:0] : {r_rem[DW-2:0], r_num[NB-1]};
            r_num <= {r_num[NB-2:0], ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (r_state == D_FIX) begin
            o_slope <= res[SW-1:0];
        end
    end

endmodule

// ----- hdl/lidar_scan_segment_leg_detector_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lidar_scan_segment_leg_detector_unit: scan segmenter and leg detector
// Splits a stream of scan points into segments at distance jumps and at the
// end of a scan, and reports each kept segment with its end points, floor
// midpoint, neighbour slope extremes and a leg flag.
// ----------------------------------------------------------------------------
//
//  channel   dir  payload                                         handshake
//  s_axis    in   tdata: distance, point_x, point_y; tlast: eos   tvalid/tready
//  m_axis    out  tdata: ends, mid, slopes; tuser: is_leg;         tvalid/tready
//                 tlast: last_of_run
//  apb       in   4 registers at byte address 4*i, 32 bit data    psel/penable
//
//  One word at a time. A point goes through the steps accept, check, add and
//  finish, plus, when it extends a segment, the serial slope divider. A
//  report with a slope passes through the shared multiplier (chord squared
//  against diameter squared), and every report through the output stage.
//  s_axis_tready is high only while the sequencer is idle; a report waits in
//  the emit step while the output register is still full, which stalls input.
//  Reset is synchronous: registers back to defaults, no segment open.
//
module lidar_scan_segment_leg_detector_unit
    import lsld_pkg::*;
#(
    parameter int COORD_WIDTH     = COORD_WIDTH_DEF,
    parameter int SLOPE_FRAC_BITS = SLOPE_FRAC_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,

    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // distance [14:0], point_x, point_y, zero fill
    input  logic [((DIST_W + 2*COORD_WIDTH + 7) / 8) * 8 - 1:0] s_axis_tdata,
    input  logic                  s_axis_tlast,   // end_of_scan

    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // left_x, left_y, right_x, right_y, mid_x, mid_y, largest_slope,
    // smallest_slope, zero fill
    output logic [((6*COORD_WIDTH + 2*(SLOPE_INT_W + SLOPE_FRAC_BITS) + 7) / 8) * 8 - 1:0]
                                  m_axis_tdata,
    output logic                  m_axis_tuser,   // is_leg
    output logic                  m_axis_tlast,   // last_of_run

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int CW    = COORD_WIDTH;
    localparam int DW    = CW + 1;
    localparam int SW    = SLOPE_INT_W + SLOPE_FRAC_BITS;
    localparam int MW    = (DW > DIST_W + 1) ? DW : DIST_W + 1;
    localparam int SPW   = ((SW > SPREAD_W) ? SW : SPREAD_W) + 2;
    localparam int OUT_W = ((6*CW + 2*SW + 7) / 8) * 8;

    // sequencer steps
    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_CHECK  = 4'd1;
    localparam logic [3:0] ST_CLOSE  = 4'd2;
    localparam logic [3:0] ST_SQ1    = 4'd3;
    localparam logic [3:0] ST_SQ2    = 4'd4;
    localparam logic [3:0] ST_SQ3    = 4'd5;
    localparam logic [3:0] ST_SQ4    = 4'd6;
    localparam logic [3:0] ST_EMIT   = 4'd7;
    localparam logic [3:0] ST_ADD    = 4'd8;
    localparam logic [3:0] ST_DSTART = 4'd9;
    localparam logic [3:0] ST_DIV    = 4'd10;
    localparam logic [3:0] ST_FIN    = 4'd11;

    logic [3:0]              r_state;
    logic [3:0]              n_state;

    // config registers
    logic [DIST_W-1:0]       r_cfg_cluster;
    logic [DIST_W-1:0]       r_cfg_range;
    logic [DIST_W-1:0]       r_cfg_dia;
    logic [SPREAD_W-1:0]     r_cfg_spread;

    // latched input word
    logic [DIST_W-1:0]       r_d;
    logic signed [CW-1:0]    r_x;
    logic signed [CW-1:0]    r_y;
    logic                    r_eos;

    // segment state
    logic [DIST_W-1:0]       r_prev;
    logic                    r_open;
    logic [DIST_W-1:0]       r_first_d;
    logic signed [CW-1:0]    r_first_x;
    logic signed [CW-1:0]    r_first_y;
    logic signed [CW-1:0]    r_last_x;
    logic signed [CW-1:0]    r_last_y;
    logic signed [SW-1:0]    r_max;
    logic signed [SW-1:0]    r_min;
    logic                    r_has_slope;

    // work registers
    logic signed [DW-1:0]    r_cx;       // step or chord, x
    logic signed [DW-1:0]    r_cy;       // step or chord, y
    logic [2*MW-1:0]         r_prod;
    logic [2*MW:0]           r_acc;
    logic                    r_leg;
    logic                    r_eos_phase; // closing because of end of scan

    // output stage
    logic [OUT_W-1:0]        r_out_data;
    logic                    r_out_leg;
    logic                    r_out_last;
    logic                    r_out_valid;

    logic                    cfg_wr;
    logic [DIST_W-1:0]       jump;
    logic                    jump_hit;
    logic                    out_free;
    logic                    keep;
    logic signed [MW-1:0]    mul_a;
    logic signed [2*MW-1:0]  mul_p;
    logic signed [SPW-1:0]   spread;
    logic signed [SPW-1:0]   spread_thr;
    logic [DW-1:0]           sum_x;
    logic [DW-1:0]           sum_y;
    logic                    run_last;
    logic                    div_start;
    logic                    div_done;
    logic [SW-1:0]           div_slope;
    logic signed [SW-1:0]    slope;

    // ---------------------------------------------------------------- APB
    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb begin
        unique case (paddr[3:2])
            REG_CLUSTER: prdata = APB_DATA_W'(r_cfg_cluster);
            REG_RANGE:   prdata = APB_DATA_W'(r_cfg_range);
            REG_LEGDIA:  prdata = APB_DATA_W'(r_cfg_dia);
            REG_SPREAD:  prdata = APB_DATA_W'(r_cfg_spread);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_cluster <= CLUSTER_RST;
            r_cfg_range   <= RANGE_RST;
            r_cfg_dia     <= LEGDIA_RST;
            r_cfg_spread  <= SPREAD_RST;
        end else if (cfg_wr) begin
            unique case (paddr[3:2])
                REG_CLUSTER: r_cfg_cluster <= pwdata[DIST_W-1:0];
                REG_RANGE:   r_cfg_range   <= pwdata[DIST_W-1:0];
                REG_LEGDIA:  r_cfg_dia     <= pwdata[DIST_W-1:0];
                REG_SPREAD:  r_cfg_spread  <= pwdata[SPREAD_W-1:0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------- datapath
    assign s_axis_tready = (r_state == ST_IDLE);

    assign jump     = (r_d > r_prev) ? (r_d - r_prev) : (r_prev - r_d);
    assign jump_hit = r_open && (jump >= r_cfg_cluster);
    assign keep     = (r_first_d < r_cfg_range);
    assign out_free = !r_out_valid || m_axis_tready;

    // shared multiplier: chord x squared, chord y squared, diameter squared
    always_comb begin
        unique case (r_state)
            ST_SQ1:  mul_a = MW'(r_cx);
            ST_SQ2:  mul_a = MW'(r_cy);
            ST_SQ3:  mul_a = $signed({{(MW-DIST_W){1'b0}}, r_cfg_dia});
            default: mul_a = '0;
        endcase
    end
    assign mul_p = mul_a * mul_a;

    assign spread     = SPW'(r_max) - SPW'(r_min);
    assign spread_thr = $signed({{(SPW-SPREAD_W){1'b0}}, r_cfg_spread});

    // floor midpoint: arithmetic half of the widened sum
    assign sum_x = {r_first_x[CW-1], r_first_x} + {r_last_x[CW-1], r_last_x};
    assign sum_y = {r_first_y[CW-1], r_first_y} + {r_last_y[CW-1], r_last_y};

    // a jump report is last unless the same word also flushes a kept segment,
    // which then starts at this word's distance
    assign run_last = r_eos_phase || !(r_eos && (r_d < r_cfg_range));

    assign div_start = (r_state == ST_DSTART);
    assign slope     = $signed(div_slope);

    lsld_div #(
        .COORD_W (CW),
        .FRAC_W  (SLOPE_FRAC_BITS)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_dx    (r_cx),
        .i_dy    (r_cy),
        .o_done  (div_done),
        .o_slope (div_slope)
    );

    // ---------------------------------------------------------------- sequencer
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (s_axis_tvalid) n_state = ST_CHECK;
            ST_CHECK:  n_state = jump_hit ? ST_CLOSE : ST_ADD;
            ST_CLOSE: begin
                priority if (!keep)       n_state = r_eos_phase ? ST_IDLE : ST_ADD;
                else if (!r_has_slope)    n_state = ST_EMIT;
                else                      n_state = ST_SQ1;
            end
            ST_SQ1:    n_state = ST_SQ2;
            ST_SQ2:    n_state = ST_SQ3;
            ST_SQ3:    n_state = ST_SQ4;
            ST_SQ4:    n_state = ST_EMIT;
            ST_EMIT:   if (out_free) n_state = r_eos_phase ? ST_IDLE : ST_ADD;
            ST_ADD:    n_state = r_open ? ST_DSTART : ST_FIN;
            ST_DSTART: n_state = ST_DIV;
            ST_DIV:    if (div_done) n_state = ST_FIN;
            ST_FIN:    n_state = r_eos ? ST_CLOSE : ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_open      <= 1'b0;
            r_has_slope <= 1'b0;
            r_out_valid <= 1'b0;
            r_eos_phase <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_EMIT && out_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CHECK: r_eos_phase <= 1'b0;
                ST_CLOSE: r_open <= 1'b0;
                ST_ADD: begin
                    if (!r_open) begin
                        r_open      <= 1'b1;
                        r_has_slope <= 1'b0;
                    end
                end
                ST_DIV:   if (div_done) r_has_slope <= 1'b1;
                ST_FIN:   if (r_eos) r_eos_phase <= 1'b1;
                default: ;
            endcase
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (s_axis_tvalid) begin
                    r_d   <= s_axis_tdata[DIST_W-1:0];
                    r_x   <= $signed(s_axis_tdata[DIST_W +: CW]);
                    r_y   <= $signed(s_axis_tdata[DIST_W+CW +: CW]);
                    r_eos <= s_axis_tlast;
                end
            end
            ST_CLOSE: begin
                r_leg <= 1'b0;
                r_cx  <= $signed({r_last_x[CW-1], r_last_x}) -
                         $signed({r_first_x[CW-1], r_first_x});
                r_cy  <= $signed({r_last_y[CW-1], r_last_y}) -
                         $signed({r_first_y[CW-1], r_first_y});
            end
            ST_SQ1: r_prod <= mul_p;
            ST_SQ2: begin
                r_acc  <= {1'b0, r_prod};
                r_prod <= mul_p;
            end
            ST_SQ3: begin
                r_acc  <= r_acc + {1'b0, r_prod};
                r_prod <= mul_p;
            end
            ST_SQ4: r_leg <= (spread > spread_thr) && (r_acc < {1'b0, r_prod});
            ST_EMIT: begin
                if (out_free) begin
                    r_out_data <= OUT_W'({r_min, r_max, sum_y[CW:1], sum_x[CW:1],
                                          r_last_y, r_last_x, r_first_y, r_first_x});
                    r_out_leg  <= r_leg;
                    r_out_last <= run_last;
                end
            end
            ST_ADD: begin
                if (!r_open) begin
                    r_first_d <= r_d;
                    r_first_x <= r_x;
                    r_first_y <= r_y;
                    r_max     <= '0;
                    r_min     <= '0;
                end else begin
                    r_cx <= $signed({r_x[CW-1], r_x}) - $signed({r_last_x[CW-1], r_last_x});
                    r_cy <= $signed({r_y[CW-1], r_y}) - $signed({r_last_y[CW-1], r_last_y});
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    priority if (!r_has_slope) begin
                        r_max <= slope;
                        r_min <= slope;
                    end else begin
                        if (slope > r_max) r_max <= slope;
                        if (slope < r_min) r_min <= slope;
                    end
                end
            end
            ST_FIN: begin
                r_last_x <= r_x;
                r_last_y <= r_y;
                r_prev   <= r_d;
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tuser  = r_out_leg;
    assign m_axis_tlast  = r_out_last;

endmodule
